>>> rtl/bpa_pkg.sv
package bpa_pkg;

  // Widths of the map words and of the fixed payload fields.
  localparam int WORD_W      = 32;
  localparam int WORD_IW     = 5;
  localparam int CMD_W       = 2;
  localparam int ADDR_IN_W   = 32;
  localparam int PADDR_W     = 28;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 17;
  localparam int RES_W       = 17;
  localparam int IN_DATA_W   = 32;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 72;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int DEF_PAGE_COUNT = 65536;
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int RES_RESET      = 384;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NONE       = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_MISALIGNED = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_ALREADY    = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] REG_RESERVED = 3'd0;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic               found;
    logic [WORD_IW-1:0] idx;
  } fz_result_t;

endpackage

>>> rtl/bpa_first_zero.sv
module bpa_first_zero (
  input  bpa_pkg::word_t      word,
  output bpa_pkg::fz_result_t res
);
  import bpa_pkg::*;

  // Lowest clear bit of one map word; scanned from the top so the lowest wins.
  always_comb begin
    res.found = 1'b0;
    res.idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.found = 1'b1;
        res.idx   = WORD_IW'(i);
      end
    end
  end

endmodule

>>> rtl/bitmap_page_allocator_unit.sv
// First-fit page allocator over a bitmap with one used bit per page, kept in a
// data memory of 32-bit words, plus a summary memory with one "word full" bit
// per data word. An allocate walks the summary memory one word per cycle from
// the bottom until it meets a word with a clear bit, then reads that data word.
// An init command and the end of reset rewrite every data word, one per cycle,
// and no transaction is taken until that pass is done; the result of an init
// follows that pass. A finished result waits in the output register while the
// next command is taken. PAGE_BYTES must be a power of two. The reserved_pages
// register sits at byte address 0 and takes effect at the next init.
module bitmap_page_allocator_unit #(
  parameter int PAGE_COUNT = bpa_pkg::DEF_PAGE_COUNT,
  parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // free_address[31:0]
  input  logic [bpa_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd[1:0]
  input  logic [bpa_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // page_address[27:0], status[30:28], free_count[47:31], used_count[64:48]
  output logic [bpa_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bpa_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [bpa_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import bpa_pkg::*;

  localparam int DATA_WORDS = (PAGE_COUNT + WORD_W - 1) / WORD_W;
  localparam int SUM_WORDS  = (DATA_WORDS + WORD_W - 1) / WORD_W;
  localparam int DA_W       = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int SA_W       = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int PI_W       = $clog2(PAGE_COUNT);
  localparam int PG_W       = $clog2(PAGE_COUNT + 1);
  localparam int PB_LOG     = $clog2(PAGE_BYTES);
  localparam int D_TAIL_N   = PAGE_COUNT % WORD_W;
  localparam int S_TAIL_N   = DATA_WORDS % WORD_W;
  localparam logic [31:0] PC32      = 32'(PAGE_COUNT);
  localparam logic [31:0] DW32      = 32'(DATA_WORDS);
  localparam logic [31:0] D_LAST32  = 32'(DATA_WORDS - 1);
  localparam logic [31:0] S_LAST32  = 32'(SUM_WORDS - 1);
  localparam word_t       D_TAIL    = (D_TAIL_N == 0) ? '0 : ~((word_t'(1) << D_TAIL_N) - 1'b1);
  localparam word_t       S_TAIL    = (S_TAIL_N == 0) ? '0 : ~((word_t'(1) << S_TAIL_N) - 1'b1);
  localparam logic [DA_W-1:0] D_LAST = DA_W'(DATA_WORDS - 1);
  localparam logic [SA_W-1:0] S_LAST = SA_W'(SUM_WORDS - 1);
  localparam logic [PG_W-1:0] N_RST  =
    PG_W'((RES_RESET > PAGE_COUNT) ? PAGE_COUNT : RES_RESET);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_ALLOC  = 3'd3;
  localparam logic [2:0] S_FREE   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  // Word idx of a map whose first cnt bits are set, with the bits past the end
  // of the map forced set in the last word.
  function automatic word_t prefix_word(input logic [31:0] idx, input logic [31:0] cnt,
                                        input logic [31:0] last, input word_t tail);
    word_t w;
    if (idx < (cnt >> WORD_IW)) begin
      w = '1;
    end else if (idx == (cnt >> WORD_IW)) begin
      w = (word_t'(1) << cnt[WORD_IW-1:0]) - 1'b1;
    end else begin
      w = '0;
    end
    if (idx == last) begin
      w = w | tail;
    end
    return w;
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [RES_W-1:0]    reserved_r;
  logic [PG_W-1:0]     used_r, used_nxt;
  logic [PG_W-1:0]     n_r, n_nxt;
  logic [DA_W-1:0]     clr_r, clr_nxt;
  logic                init_res_r, init_res_nxt;
  logic [SA_W-1:0]     scan_r, scan_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [SA_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic [SA_W-1:0]     s_r, s_nxt;
  logic [WORD_IW-1:0]  j_r, j_nxt;
  word_t               sw_r, sw_nxt;
  logic [DA_W-1:0]     k_r, k_nxt;
  logic [PI_W-1:0]     pg_r, pg_nxt;
  logic [STATUS_W-1:0] stat_r, stat_nxt;
  logic [PADDR_W-1:0]  res_addr_r, res_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  word_t               dmem [DATA_WORDS];
  word_t               smem [SUM_WORDS];
  word_t               dmem_q_r, smem_q_r;
  logic                dmem_we, smem_we;
  logic [DA_W-1:0]     dmem_waddr, dmem_raddr;
  logic [SA_W-1:0]     smem_waddr, smem_raddr;
  word_t               dmem_wdata, smem_wdata;

  word_t               fz_word;
  fz_result_t          fz;

  logic                in_acc;
  logic [31:0]         fpg32;
  logic [PI_W-1:0]     alloc_pg;
  logic [63:0]         alloc_pa;
  logic [31:0]         full_words;
  logic [31:0]         res_clamp;
  word_t               clr_word;
  logic [COUNT_W-1:0]  used17, free17;

  // One priority finder serves both the summary word during the scan and the
  // data word once the scan has picked it.
  assign fz_word = (state_r == S_SCAN) ? smem_q_r : dmem_q_r;

  bpa_first_zero u_fz (
    .word (fz_word),
    .res  (fz)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1:2] == REG_RESERVED[CFG_ADDR_W-1:2])
                      ? CFG_DATA_W'(reserved_r) : '0;

  assign fpg32      = in_tdata >> PB_LOG;
  assign alloc_pg   = PI_W'((32'(k_r) << WORD_IW) | 32'(fz.idx));
  assign alloc_pa   = 64'(alloc_pg) << PB_LOG;
  assign full_words = (32'(n_r) == PC32) ? DW32 : (32'(n_r) >> WORD_IW);
  assign res_clamp  = (32'(reserved_r) > PC32) ? PC32 : 32'(reserved_r);
  assign clr_word   = dmem_q_r & ~(word_t'(1) << (32'(pg_r) & 32'(WORD_W - 1)));
  assign used17     = COUNT_W'(32'(used_r));
  assign free17     = COUNT_W'(PC32 - 32'(used_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= RES_W'(RES_RESET);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[CFG_ADDR_W-1:2] == REG_RESERVED[CFG_ADDR_W-1:2]) begin
      reserved_r <= cfg_pwdata[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (dmem_we) begin
      dmem[dmem_waddr] <= dmem_wdata;
    end
    dmem_q_r <= dmem[dmem_raddr];
  end

  always_ff @(posedge clk) begin
    if (smem_we) begin
      smem[smem_waddr] <= smem_wdata;
    end
    smem_q_r <= smem[smem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    n_nxt         = n_r;
    clr_nxt       = clr_r;
    init_res_nxt  = init_res_r;
    scan_nxt      = scan_r;
    chk_v_nxt     = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    s_nxt         = s_r;
    j_nxt         = j_r;
    sw_nxt        = sw_r;
    k_nxt         = k_r;
    pg_nxt        = pg_r;
    stat_nxt      = stat_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    dmem_we       = 1'b0;
    smem_we       = 1'b0;
    dmem_waddr    = clr_r;
    smem_waddr    = SA_W'(32'(clr_r));
    dmem_wdata    = '0;
    smem_wdata    = '0;
    dmem_raddr    = DA_W'(fpg32 >> WORD_IW);
    smem_raddr    = SA_W'(fpg32 >> (2 * WORD_IW));

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          stat_nxt     = STAT_OK;
          res_addr_nxt = '0;
          case (in_tuser)
            CMD_ALLOC: begin
              if (32'(used_r) == PC32) begin
                stat_nxt  = STAT_NONE;
                state_nxt = S_RESULT;
              end else begin
                scan_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            CMD_FREE: begin
              if (|in_tdata[PB_LOG-1:0]) begin
                stat_nxt  = STAT_MISALIGNED;
                state_nxt = S_RESULT;
              end else if (fpg32 >= PC32) begin
                stat_nxt  = STAT_RANGE;
                state_nxt = S_RESULT;
              end else begin
                pg_nxt    = PI_W'(fpg32);
                state_nxt = S_FREE;
              end
            end
            CMD_INIT: begin
              n_nxt        = PG_W'(res_clamp);
              clr_nxt      = '0;
              init_res_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            default: begin
              state_nxt = S_RESULT;
            end
          endcase
        end
      end
      S_CLEAR: begin
        dmem_we    = 1'b1;
        dmem_wdata = prefix_word(32'(clr_r), 32'(n_r), D_LAST32, D_TAIL);
        smem_we    = (32'(clr_r) <= S_LAST32);
        smem_wdata = prefix_word(32'(clr_r), full_words, S_LAST32, S_TAIL);
        clr_nxt    = clr_r + DA_W'(1);
        if (clr_r == D_LAST) begin
          used_nxt  = n_r;
          state_nxt = init_res_r ? S_RESULT : S_IDLE;
        end
      end
      S_SCAN: begin
        // Summary reads go out back to back; each comes back in the next cycle.
        smem_raddr  = scan_r;
        scan_nxt    = (scan_r == S_LAST) ? scan_r : scan_r + SA_W'(1);
        chk_v_nxt   = 1'b1;
        chk_idx_nxt = scan_r;
        if (chk_v_r && fz.found) begin
          chk_v_nxt  = 1'b0;
          s_nxt      = chk_idx_r;
          j_nxt      = fz.idx;
          sw_nxt     = smem_q_r;
          k_nxt      = DA_W'((32'(chk_idx_r) << WORD_IW) | 32'(fz.idx));
          dmem_raddr = DA_W'((32'(chk_idx_r) << WORD_IW) | 32'(fz.idx));
          state_nxt  = S_ALLOC;
        end else if (chk_v_r && chk_idx_r == S_LAST) begin
          chk_v_nxt = 1'b0;
          stat_nxt  = STAT_NONE;
          state_nxt = S_RESULT;
        end
      end
      S_ALLOC: begin
        dmem_we      = 1'b1;
        dmem_waddr   = k_r;
        dmem_wdata   = dmem_q_r | (word_t'(1) << fz.idx);
        smem_waddr   = s_r;
        smem_wdata   = sw_r | (word_t'(1) << j_r);
        smem_we      = &(dmem_q_r | (word_t'(1) << fz.idx));
        used_nxt     = used_r + PG_W'(1);
        res_addr_nxt = alloc_pa[PADDR_W-1:0];
        state_nxt    = S_RESULT;
      end
      S_FREE: begin
        dmem_waddr = DA_W'(32'(pg_r) >> WORD_IW);
        dmem_wdata = clr_word;
        smem_waddr = SA_W'(32'(pg_r) >> (2 * WORD_IW));
        smem_wdata = smem_q_r & ~(word_t'(1) << ((32'(pg_r) >> WORD_IW) & 32'(WORD_W - 1)));
        if (dmem_q_r[WORD_IW'(32'(pg_r) & 32'(WORD_W - 1))]) begin
          dmem_we  = 1'b1;
          smem_we  = 1'b1;
          used_nxt = (used_r != '0) ? used_r - PG_W'(1) : used_r;
        end else begin
          stat_nxt = STAT_ALREADY;
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'b0, used17, free17, stat_r, res_addr_r};
          init_res_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      used_r      <= N_RST;
      n_r         <= N_RST;
      clr_r       <= '0;
      init_res_r  <= 1'b0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      n_r         <= n_nxt;
      clr_r       <= clr_nxt;
      init_res_r  <= init_res_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    chk_idx_r  <= chk_idx_nxt;
    s_r        <= s_nxt;
    j_r        <= j_nxt;
    sw_r       <= sw_nxt;
    k_r        <= k_nxt;
    pg_r       <= pg_nxt;
    stat_r     <= stat_nxt;
    res_addr_r <= res_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= PC32)
    else $error("used page count exceeds the pool");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command taken while another is in flight");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_RESULT))
    else $error("result raised outside the result step");

  a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC |=> used_r == $past(used_r) + PG_W'(1))
    else $error("allocation did not bump the used count");

endmodule

>>> test/tb_bitmap_page_allocator_unit.sv
`timescale 1ns / 100ps

module tb_bitmap_page_allocator_unit;
  import bpa_pkg::*;

  localparam int PAGE_COUNT = DEF_PAGE_COUNT;
  localparam int PAGE_BYTES = DEF_PAGE_BYTES;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS = 320;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int ST_LO = PADDR_W;
  localparam int FREE_LO = ST_LO + STATUS_W;
  localparam int USED_LO = FREE_LO + COUNT_W;

  typedef struct packed {
    logic [PADDR_W-1:0]  page_address;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  used_count;
  } page_result_t;

  typedef struct packed {
    logic                  set_reserved;
    logic [CFG_DATA_W-1:0] reserved_val;
    logic [CMD_W-1:0]      cmd;
    logic [31:0]           addr;
    logic                  typed;
    page_result_t          res;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic [IN_USER_W-1:0]   in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  bitmap_page_allocator_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // Shadow copy of the allocator: page bitmap, used count and reserved register.
  // Every page below first_free_hint is known to be used.
  bit           page_used [PAGE_COUNT];
  int unsigned  used_pages;
  int unsigned  first_free_hint;
  logic [RES_W-1:0] reserved_reg;

  page_result_t pending_results [$];
  int errors = 0;
  int sent_count = 0;
  int result_count = 0;
  int idle_cycles = 0;
  int settings_used = 0;
  int cmd_seen [4];
  int status_seen [8];

  function automatic void rebuild_pool();
    int unsigned n;
    n = (reserved_reg > PAGE_COUNT) ? PAGE_COUNT : reserved_reg;
    for (int i = 0; i < PAGE_COUNT; i++) page_used[i] = (i < n);
    used_pages = n;
    first_free_hint = n;
  endfunction

  function automatic page_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                 input logic [31:0] addr);
    page_result_t r;
    int unsigned  pg;
    r = '0;
    r.status = STAT_OK;
    case (cmd)
      CMD_ALLOC: begin
        r.status = STAT_NONE;
        pg = first_free_hint;
        while (pg < PAGE_COUNT && page_used[pg]) pg++;
        first_free_hint = pg;
        if (pg < PAGE_COUNT) begin
          page_used[pg] = 1'b1;
          used_pages++;
          first_free_hint = pg + 1;
          r.page_address = PADDR_W'(pg * PAGE_BYTES);
          r.status = STAT_OK;
        end
      end
      CMD_FREE: begin
        pg = addr / PAGE_BYTES;
        if (addr % PAGE_BYTES != 0) r.status = STAT_MISALIGNED;
        else if (pg >= PAGE_COUNT) r.status = STAT_RANGE;
        else if (!page_used[pg]) r.status = STAT_ALREADY;
        else begin
          page_used[pg] = 1'b0;
          if (used_pages > 0) used_pages--;
          if (pg < first_free_hint) first_free_hint = pg;
        end
      end
      CMD_INIT: rebuild_pool();
      default: ;
    endcase
    r.free_count = COUNT_W'(PAGE_COUNT - used_pages);
    r.used_count = COUNT_W'(used_pages);
    return r;
  endfunction

  // Sends one command; the expected result is computed when the transaction
  // is accepted. in_tvalid is left high so the next call can follow directly.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [31:0] addr,
                       input logic typed, input page_result_t typed_res);
    int gap;
    page_result_t r;
    gap = (sent_count % 256 < 48) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= addr;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    r = apply_command(cmd, addr);
    pending_results.push_back(typed ? typed_res : r);
    sent_count++;
    cmd_seen[cmd]++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reserved(input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] rd;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_RESERVED;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    reserved_reg = value[RES_W-1:0];
    settings_used++;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[RES_W-1:0] !== value[RES_W-1:0]) begin
      errors++;
      if (errors <= 10)
        $display("reserved_pages readback: expected %0d, got %0d",
                 value[RES_W-1:0], rd[RES_W-1:0]);
    end
  endtask

  // Result side: compare each result against the oldest expectation, then stall at random.
  always @(posedge clk) begin
    page_result_t exp_r;
    page_result_t got;
    int stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      stall = 0;
      if (out_tvalid && out_tready) begin
        got.page_address = out_tdata[PADDR_W-1:0];
        got.status = out_tdata[ST_LO +: STATUS_W];
        got.free_count = out_tdata[FREE_LO +: COUNT_W];
        got.used_count = out_tdata[USED_LO +: COUNT_W];
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result with nothing expected: %h", out_tdata);
        end else begin
          exp_r = pending_results.pop_front();
          if (got.page_address !== exp_r.page_address || got.status !== exp_r.status ||
              got.free_count !== exp_r.free_count || got.used_count !== exp_r.used_count) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: expected addr=%h st=%0d free=%0d used=%0d, got addr=%h st=%0d free=%0d used=%0d",
                       result_count, exp_r.page_address, exp_r.status, exp_r.free_count,
                       exp_r.used_count, got.page_address, got.status, got.free_count,
                       got.used_count);
          end
        end
        status_seen[got.status]++;
        result_count++;
        stall = (result_count % 200 < 40) ? 0 : $urandom_range(0, 5);
      end
      out_tready <= (stall == 0);
      if (stall > 0) begin
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Directed rows: reserved-pages writes come with an init so they take effect.
  dir_row_t dir_rows [25] = '{
    '{1'b0, 32'd0, CMD_ALLOC, 32'h0, 1'b1, '{28'h0180000, STAT_OK, 17'd65151, 17'd385}},
    '{1'b0, 32'd0, CMD_FREE, 32'h0018_0000, 1'b1, '{28'h0, STAT_OK, 17'd65152, 17'd384}},
    '{1'b0, 32'd0, CMD_FREE, 32'h0018_0000, 1'b1, '{28'h0, STAT_ALREADY, 17'd65152, 17'd384}},
    '{1'b0, 32'd0, CMD_FREE, 32'h0018_0001, 1'b1, '{28'h0, STAT_MISALIGNED, 17'd65152, 17'd384}},
    '{1'b0, 32'd0, CMD_FREE, 32'hFFFF_FFFF, 1'b1, '{28'h0, STAT_MISALIGNED, 17'd65152, 17'd384}},
    '{1'b0, 32'd0, CMD_FREE, 32'h1000_0000, 1'b1, '{28'h0, STAT_RANGE, 17'd65152, 17'd384}},
    '{1'b0, 32'd0, CMD_FREE, 32'hFFFF_F000, 1'b1, '{28'h0, STAT_RANGE, 17'd65152, 17'd384}},
    '{1'b0, 32'd0, CMD_FREE, 32'h0, 1'b1, '{28'h0, STAT_OK, 17'd65153, 17'd383}},
    '{1'b0, 32'd0, CMD_ALLOC, 32'h0, 1'b1, '{28'h0, STAT_OK, 17'd65152, 17'd384}},
    '{1'b0, 32'd0, CMD_UNUSED, 32'hA5A5_A5A5, 1'b1, '{28'h0, STAT_OK, 17'd65152, 17'd384}},
    '{1'b0, 32'd0, CMD_FREE, 32'h0FFF_F000, 1'b1, '{28'h0, STAT_ALREADY, 17'd65152, 17'd384}},
    '{1'b1, 32'd65536, CMD_INIT, 32'h0, 1'b1, '{28'h0, STAT_OK, 17'd0, 17'd65536}},
    '{1'b0, 32'd0, CMD_ALLOC, 32'h0, 1'b1, '{28'h0, STAT_NONE, 17'd0, 17'd65536}},
    '{1'b0, 32'd0, CMD_FREE, 32'h0FFF_F000, 1'b1, '{28'h0, STAT_OK, 17'd1, 17'd65535}},
    '{1'b0, 32'd0, CMD_ALLOC, 32'h0, 1'b1, '{28'hFFFF000, STAT_OK, 17'd0, 17'd65536}},
    '{1'b1, 32'hFFFF_FFFF, CMD_INIT, 32'h0, 1'b1, '{28'h0, STAT_OK, 17'd0, 17'd65536}},
    '{1'b0, 32'd0, CMD_ALLOC, 32'h5A5A_5A5A, 1'b1, '{28'h0, STAT_NONE, 17'd0, 17'd65536}},
    '{1'b1, 32'd0, CMD_INIT, 32'h0, 1'b1, '{28'h0, STAT_OK, 17'd65536, 17'd0}},
    '{1'b0, 32'd0, CMD_ALLOC, 32'h0, 1'b1, '{28'h0, STAT_OK, 17'd65535, 17'd1}},
    '{1'b0, 32'd0, CMD_FREE, 32'h0000_1000, 1'b1, '{28'h0, STAT_ALREADY, 17'd65535, 17'd1}},
    '{1'b1, 32'd65534, CMD_INIT, 32'h0, 1'b1, '{28'h0, STAT_OK, 17'd2, 17'd65534}},
    '{1'b0, 32'd0, CMD_ALLOC, 32'h0, 1'b0, '0},
    '{1'b0, 32'd0, CMD_ALLOC, 32'h0, 1'b0, '0},
    '{1'b0, 32'd0, CMD_ALLOC, 32'h0, 1'b1, '{28'h0, STAT_NONE, 17'd0, 17'd65536}},
    '{1'b1, 32'd384, CMD_INIT, 32'h0, 1'b1, '{28'h0, STAT_OK, 17'd65152, 17'd384}}
  };

  initial begin
    int unsigned phase_reserved [5];
    int unsigned hi;
    int          pick;
    logic [CMD_W-1:0] cmd;
    logic [31:0] addr;

    phase_reserved = '{384, 0, 65472, $urandom_range(1, 4000), 65530};
    reserved_reg = RES_W'(RES_RESET);
    rebuild_pool();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_reserved) begin
        drain();
        write_reserved(dir_rows[i].reserved_val);
      end
      issue(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].typed, dir_rows[i].res);
    end

    foreach (phase_reserved[p]) begin
      drain();
      write_reserved(phase_reserved[p]);
      issue(CMD_INIT, $urandom, 1'b0, '0);
      for (int k = 1; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        addr = $urandom;
        cmd = CMD_FREE;
        if (pick < 45) begin
          cmd = CMD_ALLOC;
        end else if (pick < 75) begin
          // Mostly pages that are in use, with some free ones just above.
          hi = first_free_hint + 32;
          if (hi > PAGE_COUNT - 1) hi = PAGE_COUNT - 1;
          addr = $urandom_range(0, hi) * PAGE_BYTES;
        end else if (pick < 82) begin
          addr = $urandom_range(PAGE_COUNT - 64, PAGE_COUNT - 1) * PAGE_BYTES;
        end else if (pick < 87) begin
          if (addr % PAGE_BYTES == 0) addr[0] = 1'b1;
        end else if (pick < 91) begin
          addr = {4'($urandom_range(1, 15)), 16'($urandom), 12'h000};
        end else if (pick < 95) begin
          cmd = CMD_FREE;
        end else if (pick < 98) begin
          cmd = CMD_UNUSED;
        end else begin
          cmd = CMD_INIT;
        end
        issue(cmd, addr, 1'b0, '0);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("%0d commands: %0d allocate, %0d free, %0d init, %0d unused; %0d settings of reserved_pages",
             sent_count, cmd_seen[CMD_ALLOC], cmd_seen[CMD_FREE], cmd_seen[CMD_INIT],
             cmd_seen[CMD_UNUSED], settings_used);
    $display("%0d results: %0d ok, %0d pool full, %0d misaligned, %0d out of range, %0d double free",
             result_count, status_seen[STAT_OK], status_seen[STAT_NONE],
             status_seen[STAT_MISALIGNED], status_seen[STAT_RANGE], status_seen[STAT_ALREADY]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
